// ===== src/rfd_pkg.sv =====
package rfd_pkg;

   localparam int MAX_PAYLOAD = 2048;
   localparam int PAYLOAD_COUNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int LENGTH_W = 16;
   localparam int COMMAND_W = 16;
   localparam int BYTE_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int MATCH_W = 3;

   localparam logic [COMMAND_W-1:0] EDIT_CMD_RESET = 16'h1070;
   localparam logic [BYTE_W-1:0] FIELD_CAP_RESET = 8'd49;

   localparam logic [BYTE_W-1:0] HDR_FIRST = 8'h53;
   localparam logic [BYTE_W-1:0] COLON_CHAR = 8'h3A;
   localparam logic [MATCH_W-1:0] HDR_LEN = 3'd3;
   localparam logic [MATCH_W-1:0] TAIL_CHECK_LEN = 3'd3;
   localparam logic [MATCH_W-1:0] TAIL_LAST = 3'd4;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_BODY = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE   = 3'd0,
      K_NAME   = 3'd1,
      K_VALUE  = 3'd2,
      K_DATA   = 3'd3,
      K_KEY    = 3'd4,
      K_ACCEPT = 3'd5,
      K_REJECT = 3'd6
   } kind_type;

   typedef enum logic [0:0] {
      REG_EDIT_CMD  = 1'b0,
      REG_FIELD_CAP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] edit_cmd;
      logic [BYTE_W-1:0]    field_cap;
   } cfg_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_W-1:0]    out_byte;
      logic [COMMAND_W-1:0] frame_command;
   } result_type;

   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = 8'h53;
         2'd1:    b = 8'h54;
         2'd2:    b = 8'h3C;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] tail_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = 8'h3E;
         2'd1:    b = 8'h45;
         2'd2:    b = 8'h54;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/rfd_csr.sv =====
module rfd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  rfd_pkg::csr_index_type          csr_index,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rfd_pkg::cfg_type                cfg
);

   rfd_pkg::cfg_type cfg_ff;
   rfd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rfd_pkg::REG_EDIT_CMD:  cfg_in.edit_cmd = csr_wdata;
            rfd_pkg::REG_FIELD_CAP: cfg_in.field_cap = csr_wdata[rfd_pkg::BYTE_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edit_cmd <= rfd_pkg::EDIT_CMD_RESET;
         cfg_ff.field_cap <= rfd_pkg::FIELD_CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/rfd_core.sv =====
module rfd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  rfd_pkg::cfg_type            cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rfd_pkg::BYTE_W-1:0]  req_tdata,
   input  logic                        out_free,
   output logic                        adv,
   output rfd_pkg::result_type         result
);

   logic                                 in_valid_ff, in_valid_in;
   logic [rfd_pkg::BYTE_W-1:0]           in_byte_ff, in_byte_in;

   rfd_pkg::phase_type                   phase_ff, phase_in;
   logic [rfd_pkg::MATCH_W-1:0]          match_count_ff, match_count_in;
   logic [rfd_pkg::COMMAND_W-1:0]        command_reg_ff, command_reg_in;
   logic [rfd_pkg::LENGTH_W-1:0]         length_reg_ff, length_reg_in;
   logic [rfd_pkg::PAYLOAD_COUNT_W-1:0]  payload_count_ff, payload_count_in;
   logic                                 colon_seen_ff, colon_seen_in;
   logic [rfd_pkg::BYTE_W-1:0]           held_byte_ff, held_byte_in;
   logic [rfd_pkg::BYTE_W-1:0]           name_count_ff, name_count_in;
   logic [rfd_pkg::BYTE_W-1:0]           value_count_ff, value_count_in;
   logic                                 tail_ok_ff, tail_ok_in;

   logic                                 hdr_hit;
   logic [rfd_pkg::MATCH_W-1:0]          hunt_mc;
   logic [rfd_pkg::COMMAND_W-1:0]        command_new;
   logic [rfd_pkg::LENGTH_W-1:0]         length_new;
   logic                                 len_bad;
   logic [rfd_pkg::PAYLOAD_COUNT_W-1:0]  cnt_inc;
   logic                                 body_last;
   logic                                 is_edit;
   logic                                 tail_end;
   rfd_pkg::kind_type                    kind;
   logic [rfd_pkg::BYTE_W-1:0]           out_byte;

   assign adv = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || adv;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in = req_tdata;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   assign hdr_hit = in_byte_ff == rfd_pkg::hdr_byte(match_count_ff[1:0]);
   assign hunt_mc = hdr_hit ? match_count_ff + 3'd1
                            : ((in_byte_ff == rfd_pkg::HDR_FIRST) ? 3'd1 : 3'd0);
   assign command_new = {command_reg_ff[rfd_pkg::BYTE_W-1:0], in_byte_ff};
   assign length_new = {length_reg_ff[rfd_pkg::BYTE_W-1:0], in_byte_ff};
   assign len_bad = (command_reg_ff == '0) || (length_new == '0)
                    || (length_new > rfd_pkg::LENGTH_W'(rfd_pkg::MAX_PAYLOAD));
   assign cnt_inc = payload_count_ff + 1'b1;
   assign body_last = rfd_pkg::LENGTH_W'(cnt_inc) >= length_reg_ff;
   assign is_edit = command_reg_ff == cfg.edit_cmd;
   assign tail_end = match_count_ff >= rfd_pkg::TAIL_LAST;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         rfd_pkg::PH_HUNT: begin
            if (hunt_mc == rfd_pkg::HDR_LEN) phase_in = rfd_pkg::PH_CMD;
         end
         rfd_pkg::PH_CMD: begin
            if (match_count_ff != '0) phase_in = rfd_pkg::PH_LEN;
         end
         rfd_pkg::PH_LEN: begin
            if (match_count_ff != '0) phase_in = len_bad ? rfd_pkg::PH_HUNT : rfd_pkg::PH_BODY;
         end
         rfd_pkg::PH_BODY: begin
            if (body_last) phase_in = rfd_pkg::PH_TAIL;
         end
         rfd_pkg::PH_TAIL: begin
            if (tail_end) phase_in = rfd_pkg::PH_HUNT;
         end
         default: phase_in = rfd_pkg::PH_HUNT;
      endcase
   end

   always_comb begin
      match_count_in = match_count_ff;
      command_reg_in = command_reg_ff;
      length_reg_in = length_reg_ff;
      payload_count_in = payload_count_ff;
      colon_seen_in = colon_seen_ff;
      held_byte_in = held_byte_ff;
      name_count_in = name_count_ff;
      value_count_in = value_count_ff;
      tail_ok_in = tail_ok_ff;
      kind = rfd_pkg::K_NONE;
      out_byte = '0;
      unique case (phase_ff)
         rfd_pkg::PH_HUNT: begin
            match_count_in = (hunt_mc == rfd_pkg::HDR_LEN) ? 3'd0 : hunt_mc;
         end
         rfd_pkg::PH_CMD: begin
            command_reg_in = command_new;
            match_count_in = (match_count_ff == '0) ? 3'd1 : 3'd0;
         end
         rfd_pkg::PH_LEN: begin
            length_reg_in = length_new;
            match_count_in = (match_count_ff == '0) ? 3'd1 : 3'd0;
            if (match_count_ff != '0) begin
               if (len_bad) begin
                  kind = rfd_pkg::K_REJECT;
               end else begin
                  payload_count_in = '0;
                  colon_seen_in = 1'b0;
                  held_byte_in = '0;
                  name_count_in = '0;
                  value_count_in = '0;
               end
            end
         end
         rfd_pkg::PH_BODY: begin
            if (is_edit) begin
               if (!colon_seen_ff) begin
                  if (in_byte_ff == rfd_pkg::COLON_CHAR) begin
                     colon_seen_in = 1'b1;
                  end else begin
                     if ((payload_count_ff >= 2) && (name_count_ff < cfg.field_cap)) begin
                        kind = rfd_pkg::K_NAME;
                        out_byte = held_byte_ff;
                        name_count_in = name_count_ff + 8'd1;
                     end
                     held_byte_in = in_byte_ff;
                  end
               end else if (value_count_ff < cfg.field_cap) begin
                  kind = rfd_pkg::K_VALUE;
                  out_byte = in_byte_ff;
                  value_count_in = value_count_ff + 8'd1;
               end
            end else begin
               kind = body_last ? rfd_pkg::K_KEY : rfd_pkg::K_DATA;
               out_byte = in_byte_ff;
            end
            payload_count_in = cnt_inc;
            if (body_last) begin
               match_count_in = '0;
               tail_ok_in = 1'b1;
            end
         end
         rfd_pkg::PH_TAIL: begin
            if ((match_count_ff < rfd_pkg::TAIL_CHECK_LEN)
                && (in_byte_ff != rfd_pkg::tail_byte(match_count_ff[1:0]))) begin
               tail_ok_in = 1'b0;
            end
            if (tail_end) begin
               kind = tail_ok_in ? rfd_pkg::K_ACCEPT : rfd_pkg::K_REJECT;
               match_count_in = '0;
            end else begin
               match_count_in = match_count_ff + 3'd1;
            end
         end
         default: begin
            match_count_in = '0;
         end
      endcase
   end

   always_comb begin
      result.kind = kind;
      result.out_byte = out_byte;
      result.frame_command = (kind == rfd_pkg::K_NONE) ? '0 : command_reg_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff <= rfd_pkg::PH_HUNT;
         match_count_ff <= '0;
         command_reg_ff <= '0;
         length_reg_ff <= '0;
         payload_count_ff <= '0;
         colon_seen_ff <= 1'b0;
         held_byte_ff <= '0;
         name_count_ff <= '0;
         value_count_ff <= '0;
         tail_ok_ff <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (adv) begin
            phase_ff <= phase_in;
            match_count_ff <= match_count_in;
            command_reg_ff <= command_reg_in;
            length_reg_ff <= length_reg_in;
            payload_count_ff <= payload_count_in;
            colon_seen_ff <= colon_seen_in;
            held_byte_ff <= held_byte_in;
            name_count_ff <= name_count_in;
            value_count_ff <= value_count_in;
            tail_ok_ff <= tail_ok_in;
         end
      end
   end

   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rfd_pkg::PH_HUNT) |-> (match_count_ff < rfd_pkg::HDR_LEN))
      else $error("header match count out of range");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rfd_pkg::PH_BODY) |->
         (rfd_pkg::LENGTH_W'(payload_count_ff) < length_reg_ff))
      else $error("payload count passed frame length");

   a_tail_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rfd_pkg::PH_TAIL) |-> (match_count_ff <= rfd_pkg::TAIL_LAST))
      else $error("tail count out of range");

   a_tail_entry: assert property (@(posedge clock) disable iff (reset)
      (adv && (phase_ff == rfd_pkg::PH_BODY) && body_last) |=>
         ((phase_ff == rfd_pkg::PH_TAIL) && tail_ok_ff && (match_count_ff == '0)))
      else $error("tail not entered cleanly");

endmodule

// ===== src/rfd_out.sv =====
module rfd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  rfd_pkg::result_type  result,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser
);

   logic                 rsp_valid_ff, rsp_valid_in;
   rfd_pkg::result_type  rsp_word_ff, rsp_word_in;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_word_ff.frame_command, rsp_word_ff.out_byte};
   assign rsp_tuser = rsp_word_ff.kind;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.kind == rfd_pkg::K_NONE)) |->
         ((rsp_word_ff.frame_command == '0) && (rsp_word_ff.out_byte == '0)))
      else $error("empty word carries data");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      adv |-> out_free)
      else $error("result loaded over a held word");

   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_word_ff.kind == rfd_pkg::K_ACCEPT)
                        || (rsp_word_ff.kind == rfd_pkg::K_REJECT)))
         |-> (rsp_word_ff.out_byte == '0))
      else $error("status word carries a byte");

endmodule

// ===== src/display_reply_frame_deframer_unit.sv =====
// A word taken on req reaches rsp through the input register and then the result register.
// Throughput: one word per cycle while rsp_tready stays high; every req word gives exactly one rsp word.
// A held rsp word does not stop req while the input register is free.
// Reset (synchronous, active high): header hunt, counters cleared, tail flag set,
// edit command 0x1070 and field cap 49 restored, both channels empty.
module display_reply_frame_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [7:0] out_byte, [23:8] frame_command
   output logic [2:0]                      rsp_tuser,   // [2:0] kind
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  rfd_pkg::csr_index_type          csr_index,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rfd_pkg::cfg_type     cfg;
   rfd_pkg::result_type  result;
   logic                 adv;
   logic                 out_free;

   rfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_free   (out_free),
      .adv        (adv),
      .result     (result)
   );

   rfd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/display_reply_frame_deframer_unit_test.sv =====
`timescale 1ns / 1ps

module display_reply_frame_deframer_unit_test;

   localparam logic [23:0] HEADER_STR = "ST<";
   localparam logic [23:0] TAIL_STR = ">ET";
   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_STALL = 300;

   class frame_scoreboard;
      logic [15:0]         edit_cmd;
      logic [7:0]          field_cap;
      rfd_pkg::phase_type  phase;
      logic [2:0]          match_pos;
      logic [15:0]         frame_cmd;
      logic [15:0]         frame_len;
      logic [15:0]         payload_count;
      logic                colon_seen;
      logic [7:0]          held_byte;
      logic [7:0]          name_count;
      logic [7:0]          value_count;
      logic                tail_ok;
      rfd_pkg::result_type expected_replies[$];
      int                  errors;

      function new();
         edit_cmd = rfd_pkg::EDIT_CMD_RESET;
         field_cap = rfd_pkg::FIELD_CAP_RESET;
         phase = rfd_pkg::PH_HUNT;
         match_pos = '0;
         frame_cmd = '0;
         frame_len = '0;
         payload_count = '0;
         colon_seen = 1'b0;
         held_byte = '0;
         name_count = '0;
         value_count = '0;
         tail_ok = 1'b1;
         errors = 0;
      endfunction

      function void write_reg(rfd_pkg::csr_index_type idx, logic [15:0] v);
         if (idx == rfd_pkg::REG_EDIT_CMD)
            edit_cmd = v;
         else
            field_cap = v[7:0];
      endfunction

      function void note_rx_byte(logic [7:0] b);
         rfd_pkg::kind_type   k;
         logic [7:0]          ob;
         rfd_pkg::result_type r;
         k = rfd_pkg::K_NONE;
         ob = 8'h00;
         case (phase)
            rfd_pkg::PH_HUNT: begin
               if (match_pos < 3 && b == HEADER_STR[8*(2-match_pos) +: 8])
                  match_pos++;
               else
                  match_pos = (b == HEADER_STR[23:16]) ? 3'd1 : 3'd0;
               if (match_pos >= 3) begin
                  phase = rfd_pkg::PH_CMD;
                  match_pos = '0;
               end
            end
            rfd_pkg::PH_CMD: begin
               frame_cmd = {frame_cmd[7:0], b};
               if (match_pos == 0) begin
                  match_pos = 3'd1;
               end else begin
                  match_pos = '0;
                  phase = rfd_pkg::PH_LEN;
               end
            end
            rfd_pkg::PH_LEN: begin
               frame_len = {frame_len[7:0], b};
               if (match_pos == 0) begin
                  match_pos = 3'd1;
               end else begin
                  match_pos = '0;
                  if (frame_cmd == 0 || frame_len == 0 || frame_len > rfd_pkg::MAX_PAYLOAD) begin
                     k = rfd_pkg::K_REJECT;
                     phase = rfd_pkg::PH_HUNT;
                  end else begin
                     phase = rfd_pkg::PH_BODY;
                     payload_count = '0;
                     colon_seen = 1'b0;
                     held_byte = '0;
                     name_count = '0;
                     value_count = '0;
                  end
               end
            end
            rfd_pkg::PH_BODY: begin
               if (frame_cmd == edit_cmd) begin
                  if (!colon_seen) begin
                     if (b == rfd_pkg::COLON_CHAR) begin
                        colon_seen = 1'b1;
                     end else begin
                        if (payload_count >= 2 && name_count < field_cap) begin
                           k = rfd_pkg::K_NAME;
                           ob = held_byte;
                           name_count++;
                        end
                        held_byte = b;
                     end
                  end else if (value_count < field_cap) begin
                     k = rfd_pkg::K_VALUE;
                     ob = b;
                     value_count++;
                  end
               end else begin
                  k = (payload_count + 17'd1 == {1'b0, frame_len}) ? rfd_pkg::K_KEY
                                                                    : rfd_pkg::K_DATA;
                  ob = b;
               end
               payload_count++;
               if (payload_count >= frame_len) begin
                  phase = rfd_pkg::PH_TAIL;
                  match_pos = '0;
                  tail_ok = 1'b1;
               end
            end
            default: begin
               if (match_pos < 3 && b != TAIL_STR[8*(2-match_pos) +: 8])
                  tail_ok = 1'b0;
               if (match_pos >= 4) begin
                  k = tail_ok ? rfd_pkg::K_ACCEPT : rfd_pkg::K_REJECT;
                  phase = rfd_pkg::PH_HUNT;
                  match_pos = '0;
               end else begin
                  match_pos++;
               end
            end
         endcase
         r.kind = k;
         r.out_byte = ob;
         r.frame_command = (k == rfd_pkg::K_NONE) ? 16'h0000 : frame_cmd;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic [2:0] kind, logic [7:0] ob, logic [15:0] cmd);
         rfd_pkg::result_type e;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected word kind %0d byte %02h command %04h",
                     $time, kind, ob, cmd);
            errors++;
            return;
         end
         e = expected_replies.pop_front();
         if (e.kind !== kind || e.out_byte !== ob || e.frame_command !== cmd) begin
            $display("%0t: expected kind %0d byte %02h cmd %04h, got kind %0d byte %02h cmd %04h",
                     $time, e.kind, e.out_byte, e.frame_command, kind, ob, cmd);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [23:0]                    rsp_tdata;
   logic [2:0]                     rsp_tuser;
   logic                           csr_valid;
   logic                           csr_ready;
   rfd_pkg::csr_index_type         csr_index;
   logic [rfd_pkg::CSR_DATA_W-1:0] csr_wdata;

   frame_scoreboard sb;
   logic [7:0] stim[$];
   logic [7:0] body[$];
   int send_idle;
   int recv_idle;
   int stall_req;
   int stall_seen;
   int stall_left;
   int quiet_cycles;

   display_reply_frame_deframer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_req != stall_seen) begin
         stall_seen <= stall_req;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_reply(rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("display_reply_frame_deframer_unit_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_rx_byte(b);
      @(negedge clock);
   endtask

   task automatic send_stim();
      while (stim.size() != 0)
         send_byte(stim.pop_front());
   endtask

   task automatic write_csr(input rfd_pkg::csr_index_type idx, input logic [15:0] v);
      req_tvalid <= 1'b0;
      while (sb.expected_replies.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void put_word(logic [15:0] w);
      stim.push_back(w[15:8]);
      stim.push_back(w[7:0]);
   endfunction

   function automatic void put_header(logic [15:0] cmd, logic [15:0] len);
      stim.push_back(HEADER_STR[23:16]);
      stim.push_back(HEADER_STR[15:8]);
      stim.push_back(HEADER_STR[7:0]);
      put_word(cmd);
      put_word(len);
   endfunction

   function automatic void put_frame(logic [15:0] cmd, bit good_tail);
      logic [23:0] tail;
      int pos;
      tail = TAIL_STR;
      if (!good_tail) begin
         pos = $urandom_range(2);
         tail[8*pos +: 8] = tail[8*pos +: 8] ^ 8'($urandom_range(1, 255));
      end
      put_header(cmd, 16'(body.size()));
      foreach (body[i])
         stim.push_back(body[i]);
      stim.push_back(tail[23:16]);
      stim.push_back(tail[15:8]);
      stim.push_back(tail[7:0]);
      stim.push_back(8'($urandom_range(255)));
      stim.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == rfd_pkg::COLON_CHAR)
         b = $urandom_range(1) ? 8'h00 : 8'hFF;
      return b;
   endfunction

   function automatic int field_len();
      int r;
      r = $urandom_range(99);
      if (r < 88)
         return $urandom_range(8);
      else if (r < 99)
         return $urandom_range(40, 60);
      return $urandom_range(250, 270);
   endfunction

   function automatic void make_edit_body(int name_len, int value_len, bit with_colon);
      body.delete();
      body.push_back($urandom_range(7) == 0 ? name_char() : QUOTE_CHAR);
      repeat (name_len) body.push_back(name_char());
      body.push_back($urandom_range(7) == 0 ? name_char() : QUOTE_CHAR);
      if (with_colon) begin
         body.push_back(rfd_pkg::COLON_CHAR);
         repeat (value_len) body.push_back(8'($urandom_range(255)));
      end
   endfunction

   function automatic void make_data_body(int len);
      body.delete();
      repeat (len) body.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [15:0] other_cmd();
      logic [15:0] c;
      do c = 16'($urandom_range(1, 65535)); while (c == sb.edit_cmd);
      return c;
   endfunction

   task automatic random_frames(input int budget);
      int sent;
      int sel;
      int n;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               sel = $urandom_range(3);
               stim.push_back(sel == 0 ? HEADER_STR[23:16] :
                              sel == 1 ? HEADER_STR[15:8] : 8'($urandom_range(255)));
            end
            send_stim();
         end
         sel = $urandom_range(99);
         if (sel < 35) begin
            make_edit_body(field_len(), field_len(), 1'b1);
            put_frame(sb.edit_cmd, 1'b1);
         end else if (sel < 45) begin
            make_edit_body($urandom_range(10), 0, 1'b0);
            if ($urandom_range(5) == 0)
               void'(body.pop_back());
            put_frame(sb.edit_cmd, 1'b1);
         end else if (sel < 52) begin
            body.delete();
            if ($urandom_range(1))
               body.push_back(name_char());
            body.push_back(rfd_pkg::COLON_CHAR);
            repeat (field_len()) body.push_back(8'($urandom_range(255)));
            put_frame(sb.edit_cmd, 1'b1);
         end else if (sel < 80) begin
            make_data_body($urandom_range(1, 8));
            put_frame(other_cmd(), 1'b1);
         end else if (sel < 88) begin
            n = $urandom_range(3);
            if (n == 0)
               put_header(16'h0000, 16'($urandom_range(1, 20)));
            else if (n == 1)
               put_header(other_cmd(), 16'h0000);
            else if (n == 2)
               put_header(other_cmd(), 16'(rfd_pkg::MAX_PAYLOAD + 1));
            else
               put_header(other_cmd(), 16'($urandom_range(rfd_pkg::MAX_PAYLOAD + 1, 65535)));
         end else begin
            if ($urandom_range(1))
               make_data_body($urandom_range(1, 6));
            else
               make_edit_body($urandom_range(4), $urandom_range(4), 1'b1);
            put_frame($urandom_range(1) ? sb.edit_cmd : other_cmd(), 1'b0);
         end
         sent += stim.size();
         send_stim();
      end
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = rfd_pkg::REG_EDIT_CMD;
      csr_wdata = '0;
      send_idle = 0;
      recv_idle = 0;
      stall_req = 0;
      stall_seen = 0;
      stall_left = 0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray S in the header, zero command, oversize length, bad tail
      stim.push_back(HEADER_STR[23:16]);
      put_header(16'h0000, 16'h0001);
      put_header(16'hFFFF, 16'hFFFF);
      body.delete();
      body.push_back(8'h00);
      put_frame(16'h0001, 1'b0);
      send_stim();

      write_csr(rfd_pkg::REG_EDIT_CMD, 16'h0001);
      write_csr(rfd_pkg::REG_FIELD_CAP, 16'h0001);
      send_idle = 8;
      recv_idle = 45;
      random_frames(300);

      write_csr(rfd_pkg::REG_EDIT_CMD, 16'hFFFF);
      write_csr(rfd_pkg::REG_FIELD_CAP, 16'h00FF);
      send_idle = 45;
      recv_idle = 8;
      make_edit_body(258, 258, 1'b1);
      put_frame(sb.edit_cmd, 1'b1);
      send_stim();
      random_frames(250);

      write_csr(rfd_pkg::REG_EDIT_CMD, 16'($urandom_range(1, 65535)));
      write_csr(rfd_pkg::REG_FIELD_CAP, 16'h0000);
      send_idle = 0;
      recv_idle = 0;
      random_frames(150);

      write_csr(rfd_pkg::REG_EDIT_CMD, rfd_pkg::EDIT_CMD_RESET);
      write_csr(rfd_pkg::REG_FIELD_CAP, 16'(rfd_pkg::FIELD_CAP_RESET));
      stall_req = stall_req + 1;
      random_frames(300);

      req_tvalid <= 1'b0;
      while (sb.expected_replies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_replies.size() == 0)
         $display("display_reply_frame_deframer_unit_test passed");
      else
         $display("display_reply_frame_deframer_unit_test failed");
      $finish;
   end

endmodule

// ===== display_reply_frame_deframer_unit.f =====
src/rfd_pkg.sv
src/rfd_csr.sv
src/rfd_core.sv
src/rfd_out.sv
src/display_reply_frame_deframer_unit.sv
dv/display_reply_frame_deframer_unit_test.sv
